// File: sv/spa_pkg.sv
`default_nettype none

package spa_pkg;

    localparam int EXP_W  = 16;
    localparam int TCW    = 16;
    localparam int SCW    = 17;

    typedef enum logic [1:0] {
        FN_INS_A  = 2'd0,
        FN_INS_B  = 2'd1,
        FN_ADD    = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_TERM  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_NEW   = 2'd1,
        SEL_LEFT  = 2'd2,
        SEL_RIGHT = 2'd3
    } cell_sel_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_MERGE = 2'd1,
        FSM_EMIT  = 2'd2
    } fsm_t;

    typedef struct packed {
        logic ins;
        logic rot;
        logic clr;
    } row_ctl_t;

endpackage

`default_nettype wire

// File: sv/spa_cell.sv
`default_nettype none

module spa_cell #(
    parameter int CW = 16
) (
    input  wire logic                     clk,
    input  wire spa_pkg::cell_sel_t       sel,
    input  wire logic signed [CW-1:0]     new_coef,
    input  wire logic signed [spa_pkg::EXP_W-1:0] new_exp,
    input  wire logic signed [CW-1:0]     left_coef,
    input  wire logic signed [spa_pkg::EXP_W-1:0] left_exp,
    input  wire logic signed [CW-1:0]     right_coef,
    input  wire logic signed [spa_pkg::EXP_W-1:0] right_exp,
    output logic signed [CW-1:0]          coef,
    output logic signed [spa_pkg::EXP_W-1:0] expo,
    output logic                          le,
    output logic                          lt
);

    logic signed [CW-1:0]             coef_reg;
    logic signed [spa_pkg::EXP_W-1:0] exp_reg;

    // Each cell compares its own exponent with the incoming term.
    assign le   = exp_reg <= new_exp;
    assign lt   = exp_reg < new_exp;
    assign coef = coef_reg;
    assign expo = exp_reg;

    always_ff @(posedge clk)
    begin
        case (sel)
            spa_pkg::SEL_NEW:
            begin
                coef_reg <= new_coef;
                exp_reg  <= new_exp;
            end
            spa_pkg::SEL_LEFT:
            begin
                coef_reg <= left_coef;
                exp_reg  <= left_exp;
            end
            spa_pkg::SEL_RIGHT:
            begin
                coef_reg <= right_coef;
                exp_reg  <= right_exp;
            end
            default:
            begin
                coef_reg <= coef_reg;
                exp_reg  <= exp_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/spa_row.sv
`default_nettype none

module spa_row #(
    parameter int DEPTH = 32,
    parameter int CW    = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire spa_pkg::row_ctl_t        ctl,
    input  wire logic signed [CW-1:0]     new_coef,
    input  wire logic signed [spa_pkg::EXP_W-1:0] new_exp,
    output logic signed [CW-1:0]          head_coef,
    output logic signed [spa_pkg::EXP_W-1:0] head_exp,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic signed [CW-1:0]             c_q [DEPTH];
    logic signed [spa_pkg::EXP_W-1:0] e_q [DEPTH];
    logic [DEPTH-1:0]                 le;
    logic [DEPTH-1:0]                 lt;
    logic [DEPTH-1:0]                 move;
    logic                             front;

    // The new term goes to the front when the list is empty or it beats the head.
    assign front     = (count_reg == '0) || lt[0];
    assign head_coef = c_q[0];
    assign head_exp  = e_q[0];
    assign count     = count_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        spa_pkg::cell_sel_t               sel;
        logic signed [CW-1:0]             lc;
        logic signed [spa_pkg::EXP_W-1:0] le_x;
        logic signed [CW-1:0]             rc;
        logic signed [spa_pkg::EXP_W-1:0] re_x;
        logic                             wrap;

        if (k == 0)
        begin : g_first
            assign move[k] = front;
            assign lc      = new_coef;
            assign le_x    = new_exp;
        end
        else
        begin : g_rest
            assign move[k] = front || (count_reg <= CNT_W'(k)) || le[k];
            assign lc      = c_q[k-1];
            assign le_x    = e_q[k-1];
        end

        // On a rotate the last live entry takes the head back.
        if (k == DEPTH-1)
        begin : g_last
            assign wrap = 1'b1;
            assign rc   = c_q[0];
            assign re_x = e_q[0];
        end
        else
        begin : g_mid
            assign wrap = count_reg == CNT_W'(k+1);
            assign rc   = wrap ? c_q[0] : c_q[k+1];
            assign re_x = wrap ? e_q[0] : e_q[k+1];
        end

        always_comb
        begin
            if (ctl.ins && move[k])
            begin
                if (k == 0)
                    sel = spa_pkg::SEL_NEW;
                else if (!move[(k == 0) ? 0 : k-1])
                    sel = spa_pkg::SEL_NEW;
                else
                    sel = spa_pkg::SEL_LEFT;
            end
            else if (ctl.rot)
                sel = spa_pkg::SEL_RIGHT;
            else
                sel = spa_pkg::SEL_HOLD;
        end

        spa_cell #(.CW(CW)) u_cell (
            .clk        (clk),
            .sel        (sel),
            .new_coef   (new_coef),
            .new_exp    (new_exp),
            .left_coef  (lc),
            .left_exp   (le_x),
            .right_coef (rc),
            .right_exp  (re_x),
            .coef       (c_q[k]),
            .expo       (e_q[k]),
            .le         (le[k]),
            .lt         (lt[k])
        );
    end

    always_comb
    begin
        if (ctl.clr)
            count_next = '0;
        else if (ctl.ins)
            count_next = count_reg + CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("row count beyond depth");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins && !ctl.clr |-> count_reg != CNT_W'(DEPTH))
        else $error("insert into a full row");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins && !ctl.clr |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the row");

endmodule

`default_nettype wire

// File: sv/sparse_polynomial_adder_top.sv
// Insert and clear words: the single result word appears the cycle after the word is taken
// and busy stays low, so one such word can be taken every cycle.
// Add words: the block merges lists A and B into the sum row, one term per cycle, then takes
// a finishing step and gives one result word per sum term (at most 2*MAX_TERMS), or a single
// empty word. Reset clears the term counts and control state; cell contents stay as they are.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none

module sparse_polynomial_adder_top #(
    parameter int MAX_TERMS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] term_coefficient,
    input  wire logic signed [15:0] term_exponent,
    output logic                    result_valid,
    output logic signed [16:0]      out_coefficient,
    output logic signed [15:0]      out_exponent,
    output logic [1:0]              status,
    output logic                    last
);

    localparam int SUM_DEPTH = 2 * MAX_TERMS;
    localparam int LCW       = $clog2(MAX_TERMS+1);
    localparam int SUMW      = $clog2(SUM_DEPTH+1);

    spa_pkg::fsm_t       state_reg;
    spa_pkg::fsm_t       state_next;
    logic [LCW-1:0]      ra_reg;
    logic [LCW-1:0]      ra_next;
    logic [LCW-1:0]      rb_reg;
    logic [LCW-1:0]      rb_next;
    logic [SUMW-1:0]     em_reg;
    logic [SUMW-1:0]     em_next;

    logic                valid_reg;
    logic                valid_next;
    logic signed [16:0]  coef_reg;
    logic signed [16:0]  coef_next;
    logic signed [15:0]  exp_reg;
    logic signed [15:0]  exp_next;
    spa_pkg::status_t    status_reg;
    spa_pkg::status_t    status_next;
    logic                last_reg;
    logic                last_next;

    spa_pkg::row_ctl_t   a_ctl;
    spa_pkg::row_ctl_t   b_ctl;
    spa_pkg::row_ctl_t   s_ctl;
    logic signed [15:0]  a_hc;
    logic signed [15:0]  a_he;
    logic signed [15:0]  b_hc;
    logic signed [15:0]  b_he;
    logic signed [16:0]  s_hc;
    logic signed [15:0]  s_he;
    logic [LCW-1:0]      a_cnt;
    logic [LCW-1:0]      b_cnt;
    logic [SUMW-1:0]     s_cnt;
    logic signed [16:0]  s_new_c;
    logic signed [15:0]  s_new_e;
    logic                take;

    // Lists A and B each live in a row of cells; the sum is built in a third row.
    spa_row #(.DEPTH(MAX_TERMS), .CW(spa_pkg::TCW)) u_row_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (a_ctl),
        .new_coef  (term_coefficient),
        .new_exp   (term_exponent),
        .head_coef (a_hc),
        .head_exp  (a_he),
        .count     (a_cnt)
    );

    spa_row #(.DEPTH(MAX_TERMS), .CW(spa_pkg::TCW)) u_row_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (b_ctl),
        .new_coef  (term_coefficient),
        .new_exp   (term_exponent),
        .head_coef (b_hc),
        .head_exp  (b_he),
        .count     (b_cnt)
    );

    spa_row #(.DEPTH(SUM_DEPTH), .CW(spa_pkg::SCW)) u_row_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (s_ctl),
        .new_coef  (s_new_c),
        .new_exp   (s_new_e),
        .head_coef (s_hc),
        .head_exp  (s_he),
        .count     (s_cnt)
    );

    assign take = start && (state_reg == spa_pkg::FSM_IDLE);
    assign busy = state_reg != spa_pkg::FSM_IDLE;

    always_comb
    begin
        state_next  = state_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        em_next     = em_reg;
        valid_next  = 1'b0;
        coef_next   = '0;
        exp_next    = '0;
        status_next = spa_pkg::ST_OK;
        last_next   = 1'b0;
        a_ctl       = '0;
        b_ctl       = '0;
        s_ctl       = '0;
        s_new_c     = 17'(a_hc);
        s_new_e     = a_he;

        case (state_reg)
            spa_pkg::FSM_IDLE:
            begin
                if (take)
                begin
                    valid_next = 1'b1;
                    last_next  = 1'b1;
                    case (spa_pkg::func_t'(func))
                        spa_pkg::FN_INS_A:
                        begin
                            if (a_cnt == LCW'(MAX_TERMS))
                                status_next = spa_pkg::ST_FULL;
                            else
                                a_ctl.ins = 1'b1;
                        end
                        spa_pkg::FN_INS_B:
                        begin
                            if (b_cnt == LCW'(MAX_TERMS))
                                status_next = spa_pkg::ST_FULL;
                            else
                                b_ctl.ins = 1'b1;
                        end
                        spa_pkg::FN_CLEAR:
                        begin
                            a_ctl.clr = 1'b1;
                            b_ctl.clr = 1'b1;
                        end
                        default:
                        begin
                            // Add: the result words come later.
                            valid_next = 1'b0;
                            last_next  = 1'b0;
                            s_ctl.clr  = 1'b1;
                            ra_next    = a_cnt;
                            rb_next    = b_cnt;
                            state_next = spa_pkg::FSM_MERGE;
                        end
                    endcase
                end
            end

            spa_pkg::FSM_MERGE:
            begin
                // One merged term per cycle; the used heads rotate back to the tail.
                if (ra_reg != '0 && rb_reg != '0)
                begin
                    s_ctl.ins = 1'b1;
                    if (a_he == b_he)
                    begin
                        s_new_c   = 17'(a_hc) + 17'(b_hc);
                        a_ctl.rot = 1'b1;
                        b_ctl.rot = 1'b1;
                        ra_next   = ra_reg - LCW'(1);
                        rb_next   = rb_reg - LCW'(1);
                    end
                    else if (a_he > b_he)
                    begin
                        a_ctl.rot = 1'b1;
                        ra_next   = ra_reg - LCW'(1);
                    end
                    else
                    begin
                        s_new_c   = 17'(b_hc);
                        s_new_e   = b_he;
                        b_ctl.rot = 1'b1;
                        rb_next   = rb_reg - LCW'(1);
                    end
                end
                else if (ra_reg != '0)
                begin
                    s_ctl.ins = 1'b1;
                    a_ctl.rot = 1'b1;
                    ra_next   = ra_reg - LCW'(1);
                end
                else if (rb_reg != '0)
                begin
                    s_ctl.ins = 1'b1;
                    s_new_c   = 17'(b_hc);
                    s_new_e   = b_he;
                    b_ctl.rot = 1'b1;
                    rb_next   = rb_reg - LCW'(1);
                end
                else if (s_cnt == '0)
                begin
                    valid_next  = 1'b1;
                    last_next   = 1'b1;
                    status_next = spa_pkg::ST_EMPTY;
                    state_next  = spa_pkg::FSM_IDLE;
                end
                else
                begin
                    em_next    = s_cnt;
                    state_next = spa_pkg::FSM_EMIT;
                end
            end

            spa_pkg::FSM_EMIT:
            begin
                valid_next  = 1'b1;
                coef_next   = s_hc;
                exp_next    = s_he;
                status_next = spa_pkg::ST_TERM;
                last_next   = em_reg == SUMW'(1);
                s_ctl.rot   = 1'b1;
                em_next     = em_reg - SUMW'(1);
                if (em_reg == SUMW'(1))
                    state_next = spa_pkg::FSM_IDLE;
            end

            default:
            begin
                state_next = spa_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spa_pkg::FSM_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        em_reg     <= em_next;
        coef_reg   <= coef_next;
        exp_reg    <= exp_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign result_valid    = valid_reg;
    assign out_coefficient = coef_reg;
    assign out_exponent    = exp_reg;
    assign status          = status_reg;
    assign last            = last_reg;

    a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last)
        else $error("add finished without a final word");

    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status_reg != spa_pkg::ST_TERM |-> last)
        else $error("status word without last");

    a_emit_word: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spa_pkg::FSM_EMIT |=> result_valid && status_reg == spa_pkg::ST_TERM)
        else $error("emit cycle gave no term word");

endmodule

`default_nettype wire

// File: bench/poly_sum_checker.sv
`default_nettype none

module poly_sum_checker #(
    parameter int MAX_TERMS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] term_coefficient,
    input  wire logic signed [15:0] term_exponent,
    input  wire logic               result_valid,
    input  wire logic signed [16:0] out_coefficient,
    input  wire logic signed [15:0] out_exponent,
    input  wire logic [1:0]         status,
    input  wire logic               last,
    output int                      fail_count,
    output int                      pending_words,
    output int                      terms_seen,
    output int                      full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [16:0] coef;
        logic signed [15:0] expo;
        spa_pkg::status_t   stat;
        logic               fin;
    } result_word_t;

    typedef struct {
        logic signed [16:0] coef[$];
        logic signed [15:0] expo[$];
    } poly_t;

    poly_t        poly_a;
    poly_t        poly_b;
    result_word_t expected_words[$];

    // Ordering rule shared by the lists and the sum: the front wins only on
    // a strictly larger exponent, otherwise the term goes before the first
    // later term whose exponent is at most its own.
    function automatic void place(ref poly_t p, input logic signed [16:0] c,
                                  input logic signed [15:0] e);
        int pos;
        if (p.expo.size() == 0 || e > p.expo[0])
            pos = 0;
        else
        begin
            pos = 1;
            while (pos < p.expo.size() && p.expo[pos] > e)
                pos++;
        end
        p.coef.insert(pos, c);
        p.expo.insert(pos, e);
    endfunction

    function automatic void predict_word(spa_pkg::func_t f, logic signed [15:0] c,
                                         logic signed [15:0] e);
        poly_t        sum;
        result_word_t w;
        int           i;
        int           j;
        w = '{coef: '0, expo: '0, stat: spa_pkg::ST_OK, fin: 1'b1};
        case (f)
            spa_pkg::FN_INS_A, spa_pkg::FN_INS_B:
            begin
                if (f == spa_pkg::FN_INS_A && poly_a.expo.size() >= MAX_TERMS)
                    w.stat = spa_pkg::ST_FULL;
                else if (f == spa_pkg::FN_INS_B && poly_b.expo.size() >= MAX_TERMS)
                    w.stat = spa_pkg::ST_FULL;
                else if (f == spa_pkg::FN_INS_A)
                    place(poly_a, 17'(c), e);
                else
                    place(poly_b, 17'(c), e);
                expected_words.push_back(w);
            end
            spa_pkg::FN_CLEAR:
            begin
                poly_a.coef.delete(); poly_a.expo.delete();
                poly_b.coef.delete(); poly_b.expo.delete();
                expected_words.push_back(w);
            end
            default:
            begin
                i = 0;
                j = 0;
                while (i < poly_a.expo.size() && j < poly_b.expo.size())
                begin
                    if (poly_a.expo[i] == poly_b.expo[j])
                    begin
                        place(sum, poly_a.coef[i] + poly_b.coef[j], poly_a.expo[i]);
                        i++;
                        j++;
                    end
                    else if (poly_a.expo[i] > poly_b.expo[j])
                    begin
                        place(sum, poly_a.coef[i], poly_a.expo[i]);
                        i++;
                    end
                    else
                    begin
                        place(sum, poly_b.coef[j], poly_b.expo[j]);
                        j++;
                    end
                end
                for (; i < poly_a.expo.size(); i++)
                    place(sum, poly_a.coef[i], poly_a.expo[i]);
                for (; j < poly_b.expo.size(); j++)
                    place(sum, poly_b.coef[j], poly_b.expo[j]);
                if (sum.expo.size() == 0)
                begin
                    w.stat = spa_pkg::ST_EMPTY;
                    expected_words.push_back(w);
                end
                for (int k = 0; k < sum.expo.size(); k++)
                    expected_words.push_back('{coef: sum.coef[k], expo: sum.expo[k],
                        stat: spa_pkg::ST_TERM, fin: (k == sum.expo.size() - 1)});
            end
        endcase
    endfunction

    function automatic void report_mismatch(string what, result_word_t want,
                                            result_word_t got);
        fail_count++;
        if (fail_count <= 10)
            $display({"%0t: %s: expected coef %0d exp %0d status %0d last %0d,",
                      " got coef %0d exp %0d status %0d last %0d"},
                     $realtime, what, want.coef, want.expo, want.stat, want.fin,
                     got.coef, got.expo, got.stat, got.fin);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t got;
        result_word_t want;
        if (!rst_n)
        begin
            fail_count    <= 0;
            terms_seen    <= 0;
            full_seen     <= 0;
            pending_words <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                got = '{coef: out_coefficient, expo: out_exponent,
                        stat: spa_pkg::status_t'(status), fin: last};
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", '0, got);
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                        report_mismatch("word mismatch", want, got);
                end
                if (got.stat == spa_pkg::ST_TERM)
                    terms_seen <= terms_seen + 1;
                if (got.stat == spa_pkg::ST_FULL)
                    full_seen <= full_seen + 1;
            end
            if (start && !busy)
                predict_word(spa_pkg::func_t'(func), term_coefficient, term_exponent);
            pending_words <= expected_words.size();
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

// Stimulus driver and verdict for the sparse polynomial adder. The checker
// beside the block predicts every result word and counts mismatches.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         func;
    logic signed [15:0] term_coefficient;
    logic signed [15:0] term_exponent;
    logic               result_valid;
    logic signed [16:0] out_coefficient;
    logic signed [15:0] out_exponent;
    logic [1:0]         status;
    logic               last;
    int                 fail_count;
    int                 pending_words;
    int                 terms_seen;
    int                 full_seen;
    int                 words_sent;

    sparse_polynomial_adder_top dut (.*);

    poly_sum_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Sends one word: start rises at an edge and stays up until an edge
    // where busy is low takes the word. Busy is looked at mid-cycle, where
    // it is settled, so the accepting edge is known without a race.
    task automatic send_word(spa_pkg::func_t f, logic [15:0] c, logic [15:0] e);
        logic was_busy;
        func             <= f;
        term_coefficient <= c;
        term_exponent    <= e;
        start            <= 1'b1;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        words_sent++;
    endtask

    // Most gaps are zero or short; now and then one is long so it lands
    // in the middle of a merge or an emit.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50)
            n = 0;
        else if (n < 92)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(10, 80);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Exponents come from a narrow window half the time so that equal
    // exponents and merges of matching terms are common.
    function automatic logic [15:0] pick_exponent();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 12)) - 6);
        endcase
    endfunction

    // Random phase: fills both lists to random depths, sometimes to the limit
    // and past it, then adds once and, most of the time, clears.
    task automatic random_round();
        int n_a;
        int n_b;
        n_a = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 34)
                                            : $urandom_range(0, 8);
        n_b = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 34)
                                            : $urandom_range(0, 8);
        while (n_a > 0 || n_b > 0)
        begin
            if (n_a > 0 && (n_b == 0 || $urandom_range(0, 1)))
            begin
                send_word(spa_pkg::FN_INS_A, 16'($urandom), pick_exponent());
                n_a--;
            end
            else
            begin
                send_word(spa_pkg::FN_INS_B, 16'($urandom), pick_exponent());
                n_b--;
            end
            idle_gap();
        end
        send_word(spa_pkg::FN_ADD, 16'($urandom), 16'($urandom));
        idle_gap();
        if ($urandom_range(0, 3) != 0)
            send_word(spa_pkg::FN_CLEAR, 16'($urandom), 16'($urandom));
        idle_gap();
    endtask

    initial
    begin
        int wait_cycles;
        rst_n            = 1'b0;
        start            = 1'b0;
        func             = spa_pkg::FN_CLEAR;
        term_coefficient = '0;
        term_exponent    = '0;
        words_sent       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: add on empty lists, extreme fields, an equal
        // exponent against the head, a matching merge, and a full list.
        send_word(spa_pkg::FN_ADD, 16'h0000, 16'h0000);
        send_word(spa_pkg::FN_INS_A, 16'h7fff, 16'h7fff);
        send_word(spa_pkg::FN_INS_A, 16'h8000, 16'h8000);
        send_word(spa_pkg::FN_INS_A, 16'h1234, 16'h7fff);
        send_word(spa_pkg::FN_INS_B, 16'h7fff, 16'h7fff);
        send_word(spa_pkg::FN_INS_B, 16'h8000, 16'h8000);
        send_word(spa_pkg::FN_INS_B, 16'h0000, 16'h0005);
        send_word(spa_pkg::FN_ADD, 16'hffff, 16'hffff);
        send_word(spa_pkg::FN_CLEAR, 16'hffff, 16'hffff);
        send_word(spa_pkg::FN_INS_A, 16'h8000, 16'h0001);
        send_word(spa_pkg::FN_INS_B, 16'h8000, 16'h0001);
        send_word(spa_pkg::FN_ADD, 16'h0000, 16'h0000);
        send_word(spa_pkg::FN_CLEAR, 16'h0000, 16'h0000);
        for (int k = 0; k < 33; k++)
            send_word(spa_pkg::FN_INS_B, 16'($urandom), 16'($urandom_range(0, 3)));
        send_word(spa_pkg::FN_ADD, 16'h0000, 16'h0000);
        send_word(spa_pkg::FN_CLEAR, 16'h0000, 16'h0000);

        while (words_sent < 360)
            random_round();
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_words != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);

        $display("Sent %0d words; saw %0d sum terms and %0d rejected inserts.",
                 words_sent, terms_seen, full_seen);
        if (fail_count == 0 && pending_words == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // About 430 words, even with the longest add and the longest idle gap
    // after each, stay under a millisecond in the worst case.
    initial
    begin
        #5ms;
        $display("Timed out.");
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
